FILE: rtl/rsr_pkg.sv
// Shared types and constants for the rectangle subtraction block.
package rsr_pkg;

  // Coordinate width; positions carry one extra bit so ends never wrap
  localparam int COORD_BITS = 16;
  localparam int POS_BITS   = COORD_BITS + 1;
  localparam int NUM_PARTS  = 4;
  localparam int TOTAL_BITS = 3;

  // Result status codes
  localparam logic [1:0] ST_REGION  = 2'd0;
  localparam logic [1:0] ST_NO_HIT  = 2'd1;
  localparam logic [1:0] ST_COVERED = 2'd2;

  // Part order: top band, bottom band, left strip, right strip
  localparam int P_TOP    = 0;
  localparam int P_BOTTOM = 1;
  localparam int P_LEFT   = 2;
  localparam int P_RIGHT  = 3;

  typedef struct packed {
    logic [COORD_BITS-1:0] area_col;
    logic [COORD_BITS-1:0] area_row;
    logic [COORD_BITS-1:0] area_width;
    logic [COORD_BITS-1:0] area_height;
    logic [COORD_BITS-1:0] cut_col;
    logic [COORD_BITS-1:0] cut_row;
    logic [COORD_BITS-1:0] cut_width;
    logic [COORD_BITS-1:0] cut_height;
  } in_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]   part_col;
    logic [POS_BITS-1:0]   part_row;
    logic [COORD_BITS-1:0] part_width;
    logic [COORD_BITS-1:0] part_height;
    logic [1:0]            status;
    logic [TOTAL_BITS-1:0] part_total;
    logic                  last_part;
  } out_item_t;

  // Stage 1 result: inputs plus right and bottom ends
  typedef struct packed {
    in_item_t            item;
    logic [POS_BITS-1:0] a_right;
    logic [POS_BITS-1:0] a_bottom;
    logic [POS_BITS-1:0] c_right;
    logic [POS_BITS-1:0] c_bottom;
  } ends_t;

  // Stage 2 result: area plus intersection bounds
  typedef struct packed {
    logic [COORD_BITS-1:0] a_col;
    logic [COORD_BITS-1:0] a_row;
    logic [COORD_BITS-1:0] a_w;
    logic [POS_BITS-1:0]   a_right;
    logic [POS_BITS-1:0]   a_bottom;
    logic [POS_BITS-1:0]   i_left;
    logic [POS_BITS-1:0]   i_right;
    logic [POS_BITS-1:0]   i_top;
    logic [POS_BITS-1:0]   i_bot;
  } isect_t;

  // One uncovered piece
  typedef struct packed {
    logic [POS_BITS-1:0]   col;
    logic [POS_BITS-1:0]   row;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } part_t;

  // Stage 3 result: everything the emitter needs for one item
  typedef struct packed {
    logic [1:0]                 kind;
    logic [NUM_PARTS-1:0]       mask;
    logic [TOTAL_BITS-1:0]      total;
    part_t [NUM_PARTS-1:0]      parts;
  } parts_t;

endpackage

FILE: rtl/rectangle_subtract_regions.sv
// Top level of the rectangle subtraction block.
//
//  Channel  Ports                          Moves
//  in       in_valid, in_stall, in_data    area and cut rectangle, one per transfer
//  out      out_valid, out_stall, out_data one piece or status word per transfer
//
// Three pipeline stages (ends, intersection, pieces) feed an item buffer and the
// output register, which drives out_data.
// An item has 1 to 4 results, sent one at a time through the single result port of the
// emitter; an item with one result leaves every cycle unless out_stall holds it.
// Synchronous active-low reset clears all valid bits. out_stall backs up through
// the stages; nothing is lost or repeated while stalled.
module rectangle_subtract_regions (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsr_pkg::out_item_t out_data
);

  logic            s1_rdy;
  logic            s1_vld;
  rsr_pkg::ends_t  s1_data;
  logic            s2_rdy;
  logic            s2_vld;
  rsr_pkg::isect_t s2_data;
  logic            s3_rdy;
  logic            s3_vld;
  rsr_pkg::parts_t s3_data;
  logic            em_rdy;

  assign in_stall = !s1_rdy;

  rsr_ends u_ends (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_valid),
    .data_i (in_data),
    .rdy_o  (s1_rdy),
    .vld_o  (s1_vld),
    .data_o (s1_data),
    .rdy_i  (s2_rdy)
  );

  rsr_isect u_isect (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s1_vld),
    .data_i (s1_data),
    .rdy_o  (s2_rdy),
    .vld_o  (s2_vld),
    .data_o (s2_data),
    .rdy_i  (s3_rdy)
  );

  rsr_parts u_parts (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s2_vld),
    .data_i (s2_data),
    .rdy_o  (s3_rdy),
    .vld_o  (s3_vld),
    .data_o (s3_data),
    .rdy_i  (em_rdy)
  );

  rsr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (s3_vld),
    .data_i    (s3_data),
    .rdy_o     (em_rdy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

`ifndef SYNTHESIS
  // a status word stands alone and carries no pieces
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != rsr_pkg::ST_REGION) |->
      (out_data.last_part && out_data.part_total == '0))
    else $error("status result not a lone last result");

  // a piece always belongs to a count of one to four
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == rsr_pkg::ST_REGION) |->
      (out_data.part_total != '0 && out_data.part_total <= 3'(rsr_pkg::NUM_PARTS)))
    else $error("piece count out of range");

  // after a non-final piece the next piece follows at once with the same count
  a_next_piece: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_part) |=>
      (out_valid && out_data.status == rsr_pkg::ST_REGION &&
       out_data.part_total == $past(out_data.part_total)))
    else $error("piece sequence broken");
`endif

endmodule

FILE: rtl/rsr_ends.sv
// Pipeline stage 1: register the item and form the right and bottom ends.
module rsr_ends (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  rsr_pkg::in_item_t data_i,
  output logic             rdy_o,
  output logic             vld_o,
  output rsr_pkg::ends_t   data_o,
  input  logic             rdy_i
);

  logic           vld_r;
  rsr_pkg::ends_t data_r;
  rsr_pkg::ends_t data_nxt;

  // stage moves when empty or when the next stage takes its contents
  assign rdy_o = !vld_r || rdy_i;

  // 17-bit ends
  always_comb begin
    data_nxt.item     = data_i;
    data_nxt.a_right  = {1'b0, data_i.area_col} + {1'b0, data_i.area_width};
    data_nxt.a_bottom = {1'b0, data_i.area_row} + {1'b0, data_i.area_height};
    data_nxt.c_right  = {1'b0, data_i.cut_col} + {1'b0, data_i.cut_width};
    data_nxt.c_bottom = {1'b0, data_i.cut_row} + {1'b0, data_i.cut_height};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

FILE: rtl/rsr_isect.sv
// Pipeline stage 2: intersection bounds by max of starts and min of ends.
module rsr_isect (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  rsr_pkg::ends_t  data_i,
  output logic            rdy_o,
  output logic            vld_o,
  output rsr_pkg::isect_t data_o,
  input  logic            rdy_i
);

  localparam int P = rsr_pkg::POS_BITS;

  logic            vld_r;
  rsr_pkg::isect_t data_r;
  rsr_pkg::isect_t data_nxt;
  logic [P-1:0]    a_col_x;
  logic [P-1:0]    a_row_x;
  logic [P-1:0]    c_col_x;
  logic [P-1:0]    c_row_x;

  assign rdy_o = !vld_r || rdy_i;

  assign a_col_x = {1'b0, data_i.item.area_col};
  assign a_row_x = {1'b0, data_i.item.area_row};
  assign c_col_x = {1'b0, data_i.item.cut_col};
  assign c_row_x = {1'b0, data_i.item.cut_row};

  // max / min selection
  always_comb begin
    data_nxt.a_col    = data_i.item.area_col;
    data_nxt.a_row    = data_i.item.area_row;
    data_nxt.a_w      = data_i.item.area_width;
    data_nxt.a_right  = data_i.a_right;
    data_nxt.a_bottom = data_i.a_bottom;
    data_nxt.i_left   = (a_col_x > c_col_x) ? a_col_x : c_col_x;
    data_nxt.i_top    = (a_row_x > c_row_x) ? a_row_x : c_row_x;
    data_nxt.i_right  = (data_i.a_right < data_i.c_right) ? data_i.a_right : data_i.c_right;
    data_nxt.i_bot    = (data_i.a_bottom < data_i.c_bottom) ? data_i.a_bottom
                                                            : data_i.c_bottom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

FILE: rtl/rsr_parts.sv
// Pipeline stage 3: piece tests, piece geometry and piece count.
module rsr_parts (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  rsr_pkg::isect_t data_i,
  output logic            rdy_o,
  output logic            vld_o,
  output rsr_pkg::parts_t data_o,
  input  logic            rdy_i
);

  localparam int W = rsr_pkg::COORD_BITS;
  localparam int P = rsr_pkg::POS_BITS;
  localparam int T = rsr_pkg::TOTAL_BITS;

  logic                           vld_r;
  rsr_pkg::parts_t                data_r;
  rsr_pkg::parts_t                data_nxt;
  logic [P-1:0]                   a_col_x;
  logic [P-1:0]                   a_row_x;
  logic [P-1:0]                   top_h;
  logic [P-1:0]                   bot_h;
  logic [P-1:0]                   left_w;
  logic [P-1:0]                   right_w;
  logic [P-1:0]                   mid_h;
  logic                           no_hit;
  logic [rsr_pkg::NUM_PARTS-1:0]  mask;

  assign rdy_o = !vld_r || rdy_i;

  assign a_col_x = {1'b0, data_i.a_col};
  assign a_row_x = {1'b0, data_i.a_row};

  // sizes; each fits a coordinate once its piece is non-empty
  assign top_h   = data_i.i_top - a_row_x;
  assign bot_h   = data_i.a_bottom - data_i.i_bot;
  assign left_w  = data_i.i_left - a_col_x;
  assign right_w = data_i.a_right - data_i.i_right;
  assign mid_h   = data_i.i_bot - data_i.i_top;

  // empty intersection in either direction
  assign no_hit = (data_i.i_left >= data_i.i_right) || (data_i.i_top >= data_i.i_bot);

  always_comb begin
    mask                  = '0;
    mask[rsr_pkg::P_TOP]    = a_row_x < data_i.i_top;
    mask[rsr_pkg::P_BOTTOM] = data_i.i_bot < data_i.a_bottom;
    mask[rsr_pkg::P_LEFT]   = a_col_x < data_i.i_left;
    mask[rsr_pkg::P_RIGHT]  = data_i.i_right < data_i.a_right;
    if (no_hit) begin
      mask = '0;
    end
  end

  // piece geometry and summary
  always_comb begin
    data_nxt.parts[rsr_pkg::P_TOP].col    = a_col_x;
    data_nxt.parts[rsr_pkg::P_TOP].row    = a_row_x;
    data_nxt.parts[rsr_pkg::P_TOP].w      = data_i.a_w;
    data_nxt.parts[rsr_pkg::P_TOP].h      = top_h[W-1:0];

    data_nxt.parts[rsr_pkg::P_BOTTOM].col = a_col_x;
    data_nxt.parts[rsr_pkg::P_BOTTOM].row = data_i.i_bot;
    data_nxt.parts[rsr_pkg::P_BOTTOM].w   = data_i.a_w;
    data_nxt.parts[rsr_pkg::P_BOTTOM].h   = bot_h[W-1:0];

    data_nxt.parts[rsr_pkg::P_LEFT].col   = a_col_x;
    data_nxt.parts[rsr_pkg::P_LEFT].row   = data_i.i_top;
    data_nxt.parts[rsr_pkg::P_LEFT].w     = left_w[W-1:0];
    data_nxt.parts[rsr_pkg::P_LEFT].h     = mid_h[W-1:0];

    data_nxt.parts[rsr_pkg::P_RIGHT].col  = data_i.i_right;
    data_nxt.parts[rsr_pkg::P_RIGHT].row  = data_i.i_top;
    data_nxt.parts[rsr_pkg::P_RIGHT].w    = right_w[W-1:0];
    data_nxt.parts[rsr_pkg::P_RIGHT].h    = mid_h[W-1:0];

    data_nxt.mask  = mask;
    data_nxt.total = T'(mask[0]) + T'(mask[1]) + T'(mask[2]) + T'(mask[3]);
    if (no_hit) begin
      data_nxt.kind = rsr_pkg::ST_NO_HIT;
    end else if (mask == '0) begin
      data_nxt.kind = rsr_pkg::ST_COVERED;
    end else begin
      data_nxt.kind = rsr_pkg::ST_REGION;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

FILE: rtl/rsr_emit.sv
// Emitter: holds one item; one result per unstalled cycle goes to the output register.
module rsr_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  rsr_pkg::parts_t    data_i,
  output logic               rdy_o,
  output logic               out_valid,
  output rsr_pkg::out_item_t out_data,
  input  logic               out_stall
);

  localparam int N = rsr_pkg::NUM_PARTS;

  logic               buf_vld_r;
  rsr_pkg::parts_t    buf_r;
  logic [N-1:0]       mask_r;
  logic               out_vld_r;
  rsr_pkg::out_item_t out_r;
  rsr_pkg::out_item_t out_nxt;
  logic [1:0]         idx;
  logic [N-1:0]       rest;
  logic               last;
  logic               out_load;
  logic               emit;

  // lowest pending piece
  always_comb begin
    idx = 2'(rsr_pkg::P_RIGHT);
    if (mask_r[rsr_pkg::P_TOP]) begin
      idx = 2'(rsr_pkg::P_TOP);
    end else if (mask_r[rsr_pkg::P_BOTTOM]) begin
      idx = 2'(rsr_pkg::P_BOTTOM);
    end else if (mask_r[rsr_pkg::P_LEFT]) begin
      idx = 2'(rsr_pkg::P_LEFT);
    end
  end

  assign rest     = mask_r & ~(N'(1) << idx);
  assign last     = (buf_r.kind != rsr_pkg::ST_REGION) || (rest == '0);
  assign out_load = !out_vld_r || !out_stall;
  assign emit     = buf_vld_r && out_load;
  assign rdy_o    = !buf_vld_r || (emit && last);

  // result word for the piece being sent
  always_comb begin
    out_nxt = '0;
    out_nxt.status    = buf_r.kind;
    out_nxt.last_part = last;
    if (buf_r.kind == rsr_pkg::ST_REGION) begin
      out_nxt.part_col    = buf_r.parts[idx].col;
      out_nxt.part_row    = buf_r.parts[idx].row;
      out_nxt.part_width  = buf_r.parts[idx].w;
      out_nxt.part_height = buf_r.parts[idx].h;
      out_nxt.part_total  = buf_r.total;
    end
  end

  // item buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
    end else if (rdy_o) begin
      buf_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      buf_r  <= data_i;
      mask_r <= data_i.mask;
    end else if (emit) begin
      mask_r <= rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= buf_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the rectangle subtraction block.
`timescale 1ns / 1ps

module tb_top;

  localparam int CB = rsr_pkg::COORD_BITS;
  localparam int PB = rsr_pkg::POS_BITS;

  // One pending rectangle pair and the idle cycles before it is offered
  typedef struct {
    rsr_pkg::in_item_t rect;
    int                gap;
  } rect_job_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rsr_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rsr_pkg::out_item_t out_data;

  rect_job_t          rect_jobs [$];
  rsr_pkg::out_item_t parts_due [$];
  int                 mismatches = 0;
  bit                 tx_calm = 1'b0;
  bit                 rx_calm = 1'b0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 parts_seen = 0;
  logic               next_valid;
  rect_job_t          job;

  rectangle_subtract_regions dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // One uncovered piece, status region; total and last filled in later
  function automatic rsr_pkg::out_item_t make_part(input logic [PB-1:0] col,
                                                   input logic [PB-1:0] row,
                                                   input logic [PB-1:0] w,
                                                   input logic [PB-1:0] h);
    rsr_pkg::out_item_t p;
    p = '0;
    p.part_col    = col;
    p.part_row    = row;
    p.part_width  = w[CB-1:0];
    p.part_height = h[CB-1:0];
    p.status      = rsr_pkg::ST_REGION;
    return p;
  endfunction

  // Work out the pieces left after the cut and queue them in emission order
  function automatic void predict_parts(input rsr_pkg::in_item_t r);
    logic [PB-1:0] a_col, a_row, a_right, a_bottom, c_col, c_row;
    logic [PB-1:0] c_right, c_bottom, i_left, i_right, i_top, i_bot;
    rsr_pkg::out_item_t pieces [$];
    rsr_pkg::out_item_t p;
    a_col    = {1'b0, r.area_col};
    a_row    = {1'b0, r.area_row};
    c_col    = {1'b0, r.cut_col};
    c_row    = {1'b0, r.cut_row};
    a_right  = a_col + {1'b0, r.area_width};
    a_bottom = a_row + {1'b0, r.area_height};
    c_right  = c_col + {1'b0, r.cut_width};
    c_bottom = c_row + {1'b0, r.cut_height};
    i_left   = (a_col > c_col) ? a_col : c_col;
    i_top    = (a_row > c_row) ? a_row : c_row;
    i_right  = (a_right < c_right) ? a_right : c_right;
    i_bot    = (a_bottom < c_bottom) ? a_bottom : c_bottom;
    p = '0;
    p.last_part = 1'b1;
    // empty overlap in either direction
    if (i_left >= i_right || i_top >= i_bot) begin
      p.status = rsr_pkg::ST_NO_HIT;
      parts_due.push_back(p);
      return;
    end
    if (a_row < i_top)
      pieces.push_back(make_part(a_col, a_row, {1'b0, r.area_width}, i_top - a_row));
    if (i_bot < a_bottom)
      pieces.push_back(make_part(a_col, i_bot, {1'b0, r.area_width},
                                 a_bottom - i_bot));
    if (a_col < i_left)
      pieces.push_back(make_part(a_col, i_top, i_left - a_col, i_bot - i_top));
    if (i_right < a_right)
      pieces.push_back(make_part(i_right, i_top, a_right - i_right, i_bot - i_top));
    // cut swallows the whole area
    if (pieces.size() == 0) begin
      p.status = rsr_pkg::ST_COVERED;
      parts_due.push_back(p);
      return;
    end
    foreach (pieces[k]) begin
      p = pieces[k];
      p.part_total = rsr_pkg::TOTAL_BITS'(pieces.size());
      p.last_part  = (k == pieces.size() - 1);
      parts_due.push_back(p);
    end
  endfunction

  function automatic void check_field(input string name, input logic [PB-1:0] want,
                                      input logic [PB-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic rsr_pkg::in_item_t mk_rect(input int ac, input int ar, input int aw,
                                                input int ah, input int cc, input int cr,
                                                input int cw, input int ch);
    rsr_pkg::in_item_t r;
    r.area_col    = ac[CB-1:0];
    r.area_row    = ar[CB-1:0];
    r.area_width  = aw[CB-1:0];
    r.area_height = ah[CB-1:0];
    r.cut_col     = cc[CB-1:0];
    r.cut_row     = cr[CB-1:0];
    r.cut_width   = cw[CB-1:0];
    r.cut_height  = ch[CB-1:0];
    return r;
  endfunction

  function automatic void queue_rect(input rsr_pkg::in_item_t r);
    rect_job_t j;
    j.rect = r;
    j.gap  = tx_calm ? 0 : $urandom_range(0, 3);
    rect_jobs.push_back(j);
  endfunction

  // Values at and near both ends of the coordinate range, or any value
  function automatic int pick_edge();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return 16'hfffe;
      3:       return 16'hffff;
      default: return $urandom_range(0, 16'hffff);
    endcase
  endfunction

  // Random pair: mostly overlapping cuts near the area, some edge values and noise
  function automatic rsr_pkg::in_item_t random_rect();
    int ac, ar, aw, ah, cw, ch, sp;
    case ($urandom_range(0, 9))
      0: return mk_rect($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
      1: return mk_rect(pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                        pick_edge(), pick_edge(), pick_edge(), pick_edge());
      default: begin
        sp = ($urandom_range(0, 9) == 0) ? 16'hffff : 64;
        ac = $urandom_range(0, 16'hffff);
        ar = $urandom_range(0, 16'hffff);
        aw = $urandom_range(1, sp);
        ah = $urandom_range(1, sp);
        cw = $urandom_range(0, sp);
        ch = $urandom_range(0, sp);
        return mk_rect(ac, ar, aw, ah,
                       ac + $urandom_range(0, aw + aw / 2) - $urandom_range(0, cw),
                       ar + $urandom_range(0, ah + ah / 2) - $urandom_range(0, ch),
                       cw, ch);
      end
    endcase
  endfunction

  // Driver: offers pending pairs, predicts each one on its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_parts(in_data);
        next_valid = 1'b0;
        if (rect_jobs.size() != 0) gap_left = rect_jobs[0].gap;
      end
      if (!next_valid && rect_jobs.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          job = rect_jobs.pop_front();
          in_data <= job.rect;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: checks each result transfer, then may stall for a random spell
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      if (stall_left > 1) stall_left--;
      else out_stall <= 1'b0;
    end else if (out_valid) begin
      if (parts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        check_field("part_col", PB'(parts_due[0].part_col), PB'(out_data.part_col));
        check_field("part_row", PB'(parts_due[0].part_row), PB'(out_data.part_row));
        check_field("part_width", PB'(parts_due[0].part_width), PB'(out_data.part_width));
        check_field("part_height", PB'(parts_due[0].part_height),
                    PB'(out_data.part_height));
        check_field("status", PB'(parts_due[0].status), PB'(out_data.status));
        check_field("part_total", PB'(parts_due[0].part_total), PB'(out_data.part_total));
        check_field("last_part", PB'(parts_due[0].last_part), PB'(out_data.last_part));
        void'(parts_due.pop_front());
      end
      parts_seen++;
      if (parts_seen % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall_left = rx_calm ? 0 : $urandom_range(0, 3);
      out_stall <= (stall_left != 0);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // four pieces, covered exactly and by a larger cut
    queue_rect(mk_rect(10, 10, 20, 20, 15, 15, 5, 5));
    queue_rect(mk_rect(10, 10, 20, 20, 10, 10, 20, 20));
    queue_rect(mk_rect(10, 10, 20, 20, 0, 0, 100, 100));
    // cut touching the right and bottom ends: no overlap
    queue_rect(mk_rect(10, 10, 20, 20, 30, 10, 5, 5));
    queue_rect(mk_rect(10, 10, 20, 20, 10, 30, 5, 5));
    // zero-size area and zero-size cut
    queue_rect(mk_rect(10, 10, 0, 20, 10, 10, 5, 5));
    queue_rect(mk_rect(10, 10, 20, 20, 12, 12, 5, 0));
    // a single piece each: top, bottom, left, right
    queue_rect(mk_rect(10, 10, 20, 20, 0, 20, 100, 100));
    queue_rect(mk_rect(10, 10, 20, 20, 0, 0, 100, 15));
    queue_rect(mk_rect(10, 10, 20, 20, 20, 0, 100, 100));
    queue_rect(mk_rect(10, 10, 20, 20, 0, 0, 15, 100));
    // bands only, strips only, three pieces
    queue_rect(mk_rect(10, 10, 20, 20, 0, 15, 100, 5));
    queue_rect(mk_rect(10, 10, 20, 20, 15, 0, 5, 100));
    queue_rect(mk_rect(1000, 2000, 300, 400, 900, 2100, 150, 50));
    // range extremes: all zero, all ones, ends past the coordinate range
    queue_rect(mk_rect(0, 0, 0, 0, 0, 0, 0, 0));
    queue_rect(mk_rect(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                       16'hffff, 16'hffff, 16'hffff, 16'hffff));
    queue_rect(mk_rect(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                       16'h8000, 16'h8000, 16'hffff, 16'hffff));
    queue_rect(mk_rect(0, 0, 16'hffff, 16'hffff, 1, 1, 1, 1));
    queue_rect(mk_rect(0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    queue_rect(mk_rect(0, 0, 16'hffff, 16'hffff, 16'hfffe, 16'hfffe, 16'hffff, 16'hffff));
    queue_rect(mk_rect(0, 0, 1, 1, 0, 0, 1, 1));
    // random part, with stretches where the sender never idles
    for (int i = 0; i < 440; i++) begin
      if (i % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      queue_rect(random_rect());
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (rect_jobs.size() != 0 || in_valid) @(posedge clk);
    while (parts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
